[src/dq_pkg.sv]
// Shared types and constants for the deque with middle read.
// Holds command and status codes, widths and the cell control word.
// No dependencies.
package dq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IN_W    = ((CMD_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_W   = ((DATA_W + STAT_W + 1 + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_MIDDLE     = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-cell control: take the left neighbour, take the right neighbour,
    // or load the pushed word.
    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic load;
    } cell_ctrl_t;

endpackage

[src/dq_cell.sv]
// One storage cell of the deque chain.
// Holds a single entry and takes a neighbour's word or the pushed word.
// Depends on dq_pkg.
module dq_cell (
    input  logic                      clk,
    input  dq_pkg::cell_ctrl_t        ctrl,
    input  logic [dq_pkg::DATA_W-1:0] left_data,
    input  logic [dq_pkg::DATA_W-1:0] right_data,
    input  logic [dq_pkg::DATA_W-1:0] push_value,
    output logic [dq_pkg::DATA_W-1:0] data
);
    import dq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_right)
        begin
            data_next = left_data;
        end
        else if (ctrl.shift_left)
        begin
            data_next = right_data;
        end
        else if (ctrl.load)
        begin
            data_next = push_value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[src/deque_with_middle_read_top.sv]
// Top level of the bounded deque with middle read.
// Instantiates a row of dq_cell storage cells; depends on dq_pkg.
//
// Usage:
//   Commands arrive on the s_ stream: push front, push back, pop front,
//   pop back or read middle. Each accepted word produces exactly one
//   result word on the m_ stream: the popped or middle value, a status
//   (ok, empty, full) and a flag telling whether the deque is now empty.
//   Entries live in a chain of DEPTH cells, front entry in cell 0. A push
//   at the front shifts the whole chain one cell back, a pop at the front
//   shifts it one cell forward; push back loads the cell at the fill count
//   and pop back simply drops the count. The middle entry is cell count/2.
//   Output: the result is registered and valid in the cycle after the
//   command is accepted. Throughput: one command per cycle while each
//   result is taken on m_tready.
//   Stall: while a result waits on m_tready low, s_tready is low; a new
//   command is taken in the same cycle the waiting result leaves.
//   Reset: rst_n clears the fill count and the output valid flag, so the
//   deque starts empty. Cell contents are not cleared; an empty cell is
//   never read.
module deque_with_middle_read_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [dq_pkg::IN_W-1:0]  s_tdata,  // [2:0] command, [34:3] push_value, rest zero
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [dq_pkg::OUT_W-1:0] m_tdata   // [31:0] result_value, [33:32] status,
                                               // [34] now_empty, rest zero
);
    import dq_pkg::*;

    // Unpack the command word
    cmd_t              cmd;
    logic [DATA_W-1:0] push_value;

    assign cmd        = cmd_t'(s_tdata[CMD_W-1:0]);
    assign push_value = s_tdata[CMD_W+DATA_W-1:CMD_W];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] out_data_next;

    logic accept;
    logic full;
    logic empty;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    // Cell chain
    logic [DATA_W-1:0] cell_data [DEPTH];
    cell_ctrl_t        cell_ctrl [DEPTH];
    logic              do_shift_right;
    logic              do_shift_left;
    logic              do_load_back;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_in;
            logic [DATA_W-1:0] right_in;

            if (gi == 0)
            begin : g_first
                assign left_in = push_value;
            end
            else
            begin : g_inner_l
                assign left_in = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_in = cell_data[gi];
            end
            else
            begin : g_inner_r
                assign right_in = cell_data[gi+1];
            end

            assign cell_ctrl[gi].shift_right = do_shift_right;
            assign cell_ctrl[gi].shift_left  = do_shift_left;
            assign cell_ctrl[gi].load        = do_load_back &&
                (count_reg[IDX_W-1:0] == IDX_W'(gi));

            dq_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[gi]),
                .left_data  (left_in),
                .right_data (right_in),
                .push_value (push_value),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    // Command decode, read selection and next count
    logic [IDX_W-1:0]  rd_idx;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] res_value;
    status_t           res_status;

    assign rd_data = cell_data[rd_idx];

    always_comb
    begin
        do_shift_right = 1'b0;
        do_shift_left  = 1'b0;
        do_load_back   = 1'b0;
        count_next     = count_reg;
        res_value      = '0;
        res_status     = ST_OK;
        rd_idx         = '0;
        case (cmd)
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    do_shift_right = accept;
                    count_next     = count_reg + CNT_W'(1);
                end
            end
            CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    do_load_back = accept;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    rd_idx        = '0;
                    res_value     = rd_data;
                    do_shift_left = accept;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    rd_idx     = IDX_W'(count_reg - CNT_W'(1));
                    res_value  = rd_data;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_MIDDLE:
            begin
                if (empty)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    rd_idx    = IDX_W'(count_reg >> 1);
                    res_value = rd_data;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Output register: hold while stalled, load on accept
    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[DATA_W-1:0]               = res_value;
            out_data_next[DATA_W+STAT_W-1:DATA_W]   = res_status;
            out_data_next[DATA_W+STAT_W]            = (count_next == '0);
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
